@@ rtl/hsl_to_rgb_pixel_macros.svh @@
// Assertion macros for the HSL to RGB pixel converter checks.
// Used by the checker bound to the top level; needs clk and rst in scope.
`ifndef HSL_TO_RGB_PIXEL_MACROS_SVH
`define HSL_TO_RGB_PIXEL_MACROS_SVH

// same-cycle implication, off during reset
`define HSLRGB_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define HSLRGB_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define HSLRGB_CHECK_RESET(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/hslrgb_pkg.sv @@
// Shared types and constants for the HSL to RGB pixel converter.
// No dependencies; imported by the pipeline modules.
package hslrgb_pkg;

  localparam int NUM_STAGES = 5;

  // hue offsets of the three channels, in sixths of a turn
  localparam int RED_SIXTHS   = 2;
  localparam int GREEN_SIXTHS = 0;
  localparam int BLUE_SIXTHS  = 4;

  // piece of the hue ramp an item falls on
  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HIGH,
    SEG_FALL,
    SEG_LOW
  } seg_t;

  // load enables, one per pipeline stage
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

endpackage

@@ rtl/hslrgb_if.sv @@
// Valid/ready channel interfaces for the HSL to RGB pixel converter.
// Input carries hue, saturation, lightness; output carries the RGB bytes.
interface hslrgb_in_if #(parameter int FRAC_BITS = 16);
  logic                 valid;
  logic                 ready;
  logic [FRAC_BITS-1:0] hue;
  logic [FRAC_BITS:0]   saturation;
  logic [FRAC_BITS:0]   lightness;

  modport source (output valid, hue, saturation, lightness, input ready);
  modport sink   (input valid, hue, saturation, lightness, output ready);
endinterface

interface hslrgb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

@@ rtl/hsl_to_rgb_pixel.sv @@
// HSL to RGB pixel converter, top level: valid bits and stall control.
// Depends on hslrgb_pkg, hslrgb_if, hslrgb_front and hslrgb_chan.
//
// Usage:
//   pix_in carries one color per item: hue (Q0.F turn, wraps), saturation and
//   lightness (Q1.F, values above one are taken as one). pix_out carries the
//   red, green and blue bytes of that color, one result item per input item,
//   in input order.
//   Throughput is one item per cycle while pix_out is not stalled: five register
//   stages (clamp and l*s multiply, q/p, ramp multiplies, value, byte) each
//   take an item every clock unless the output stalls, and an accepted item
//   passes through them in that order to pix_out.valid.
//   Each stage has its own valid bit and loads whenever it is empty or the
//   stage after it moves, so bubbles close up while pix_out is stalled; the
//   held result stays stable until taken. Outside reset, pix_in.ready drops
//   only when all five stages hold items and pix_out is stalled.
//   Synchronous reset clears the valid bits and holds pix_in.ready low; the
//   block takes items from the first cycle in which rst is low.
module hsl_to_rgb_pixel #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  hslrgb_in_if.sink     pix_in,
  hslrgb_out_if.source  pix_out
);
  import hslrgb_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int VW = 2 * F + 1;

  logic [NUM_STAGES-1:0] vld;
  stage_en_t             en;

  logic [F+2:0]  h6;
  logic [VW-1:0] p2;
  logic [VW-1:0] q2;
  logic [VW-1:0] d2;
  logic [7:0]    red_level;
  logic [7:0]    green_level;
  logic [7:0]    blue_level;

  always_comb begin
    en.s5 = !vld[4] || pix_out.ready;
    en.s4 = !vld[3] || en.s5;
    en.s3 = !vld[2] || en.s4;
    en.s2 = !vld[1] || en.s3;
    en.s1 = !vld[0] || en.s2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en.s1) vld[0] <= pix_in.valid;
      if (en.s2) vld[1] <= vld[0];
      if (en.s3) vld[2] <= vld[1];
      if (en.s4) vld[3] <= vld[2];
      if (en.s5) vld[4] <= vld[3];
    end
  end

  hslrgb_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .en         (en),
    .hue        (pix_in.hue),
    .saturation (pix_in.saturation),
    .lightness  (pix_in.lightness),
    .h6         (h6),
    .p2         (p2),
    .q2         (q2),
    .d2         (d2)
  );

  hslrgb_chan #(.FRAC_BITS(FRAC_BITS), .SIXTHS(RED_SIXTHS)) u_red (
    .clk   (clk),
    .en    (en),
    .h6    (h6),
    .p2    (p2),
    .q2    (q2),
    .d2    (d2),
    .level (red_level)
  );

  hslrgb_chan #(.FRAC_BITS(FRAC_BITS), .SIXTHS(GREEN_SIXTHS)) u_green (
    .clk   (clk),
    .en    (en),
    .h6    (h6),
    .p2    (p2),
    .q2    (q2),
    .d2    (d2),
    .level (green_level)
  );

  hslrgb_chan #(.FRAC_BITS(FRAC_BITS), .SIXTHS(BLUE_SIXTHS)) u_blue (
    .clk   (clk),
    .en    (en),
    .h6    (h6),
    .p2    (p2),
    .q2    (q2),
    .d2    (d2),
    .level (blue_level)
  );

  assign pix_in.ready  = en.s1 && !rst;
  assign pix_out.valid = vld[4];
  assign pix_out.red   = red_level;
  assign pix_out.green = green_level;
  assign pix_out.blue  = blue_level;

endmodule

@@ rtl/hslrgb_front.sv @@
// Front stages: clamp saturation/lightness, form l*s and 6*hue, then q, p, q-p.
// Depends on hslrgb_pkg for the stage enables.
module hslrgb_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  hslrgb_pkg::stage_en_t     en,
  input  logic [FRAC_BITS-1:0]      hue,
  input  logic [FRAC_BITS:0]        saturation,
  input  logic [FRAC_BITS:0]        lightness,
  output logic [FRAC_BITS+2:0]      h6,
  output logic [2*FRAC_BITS:0]      p2,
  output logic [2*FRAC_BITS:0]      q2,
  output logic [2*FRAC_BITS:0]      d2
);
  import hslrgb_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int VW = 2 * F + 1;
  localparam int QW = 2 * F + 2;
  localparam logic [F:0] ONE  = (F + 1)'(1) << F;
  localparam logic [F:0] HALF = ONE >> 1;

  logic [F:0]    s_sat;
  logic [F:0]    l_sat;
  logic [QW-1:0] ls_full;
  logic [F+2:0]  h6_next;

  logic [F:0]    s1_s;
  logic [F:0]    s1_l;
  logic [VW-1:0] s1_ls;

  logic [F+1:0]  sl_sum;
  logic [QW-1:0] q_wide;
  logic [QW-1:0] l2;
  logic [QW-1:0] p_wide;
  logic [VW-1:0] q_next;
  logic [VW-1:0] p_next;
  logic [VW-1:0] d_next;

  always_comb begin
    s_sat   = (saturation > ONE) ? ONE : saturation;
    l_sat   = (lightness > ONE) ? ONE : lightness;
    ls_full = s_sat * l_sat;
    h6_next = ({3'b000, hue} << 2) + ({3'b000, hue} << 1);
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      s1_s  <= s_sat;
      s1_l  <= l_sat;
      s1_ls <= ls_full[VW-1:0];
      h6    <= h6_next;
    end
  end

  always_comb begin
    sl_sum = {1'b0, s1_s} + {1'b0, s1_l};
    if (s1_l < HALF) begin
      q_wide = QW'({s1_l, {F{1'b0}}}) + QW'(s1_ls);
    end else begin
      q_wide = QW'({sl_sum, {F{1'b0}}}) - QW'(s1_ls);
    end
    l2     = QW'({s1_l, {(F + 1){1'b0}}});
    p_wide = (l2 >= q_wide) ? (l2 - q_wide) : '0;
    q_next = q_wide[VW-1:0];
    p_next = p_wide[VW-1:0];
    d_next = (q_next >= p_next) ? (q_next - p_next) : '0;
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      q2 <= q_next;
      p2 <= p_next;
      d2 <= d_next;
    end
  end

endmodule

@@ rtl/hslrgb_chan.sv @@
// One color channel: hue position and ramp piece, ramp products, value, byte.
// Depends on hslrgb_pkg; fed by hslrgb_front.
module hslrgb_chan #(
  parameter int FRAC_BITS = 16,
  parameter int SIXTHS    = 0
) (
  input  logic                      clk,
  input  hslrgb_pkg::stage_en_t     en,
  input  logic [FRAC_BITS+2:0]      h6,
  input  logic [2*FRAC_BITS:0]      p2,
  input  logic [2*FRAC_BITS:0]      q2,
  input  logic [2*FRAC_BITS:0]      d2,
  output logic [7:0]                level
);
  import hslrgb_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int VW = 2 * F + 1;
  localparam int QW = 2 * F + 2;
  localparam int SW = 2 * F + 3;
  localparam int BW = 2 * F + 9;
  localparam logic [F+3:0] OFS    = (F + 4)'(SIXTHS) << F;
  localparam logic [F+3:0] SIX    = (F + 4)'(6) << F;
  localparam logic [F+2:0] ONE_U  = (F + 3)'(1) << F;
  localparam logic [F+2:0] THREE_U = (F + 3)'(3) << F;
  localparam logic [F+2:0] FOUR_U = (F + 3)'(4) << F;
  localparam logic [VW-1:0] FULL  = VW'(1) << (2 * F);

  logic [F+3:0]  u_sum;
  logic [F+3:0]  u_wrap;
  logic [F+2:0]  u;
  logic [F+2:0]  fall_w;
  seg_t          seg_next;
  logic [F:0]    w_next;

  seg_t          s2_seg;
  logic [F:0]    s2_w;

  logic [F:0]    d_hi;
  logic [F-1:0]  d_lo;
  logic [QW-1:0] prod_hi;
  logic [VW-1:0] prod_lo;

  seg_t          s3_seg;
  logic [QW-1:0] s3_hi;
  logic [F:0]    s3_lo;
  logic [VW-1:0] s3_p;
  logic [VW-1:0] s3_q;

  logic [SW-1:0] v_raw;
  logic [VW-1:0] v_next;
  logic [VW-1:0] s4_v;

  logic [BW-1:0] scaled;

  always_comb begin
    u_sum  = {1'b0, h6} + OFS;
    u_wrap = (u_sum >= SIX) ? (u_sum - SIX) : u_sum;
    u      = u_wrap[F+2:0];
    fall_w = FOUR_U - u;
    if (u < ONE_U) begin
      seg_next = SEG_RISE;
      w_next   = u[F:0];
    end else if (u < THREE_U) begin
      seg_next = SEG_HIGH;
      w_next   = '0;
    end else if (u < FOUR_U) begin
      seg_next = SEG_FALL;
      w_next   = fall_w[F:0];
    end else begin
      seg_next = SEG_LOW;
      w_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      s2_seg <= seg_next;
      s2_w   <= w_next;
    end
  end

  // floor(d*w >> F) split into high and low halves of d
  always_comb begin
    d_hi    = d2[VW-1:F];
    d_lo    = d2[F-1:0];
    prod_hi = d_hi * s2_w;
    prod_lo = d_lo * s2_w;
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      s3_seg <= s2_seg;
      s3_hi  <= prod_hi;
      s3_lo  <= prod_lo[VW-1:F];
      s3_p   <= p2;
      s3_q   <= q2;
    end
  end

  always_comb begin
    case (s3_seg)
      SEG_RISE, SEG_FALL: v_raw = SW'(s3_p) + SW'(s3_hi) + SW'(s3_lo);
      SEG_HIGH:           v_raw = SW'(s3_q);
      SEG_LOW:            v_raw = SW'(s3_p);
      default:            v_raw = SW'(s3_p);
    endcase
    v_next = (v_raw > SW'(FULL)) ? FULL : v_raw[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      s4_v <= v_next;
    end
  end

  // 255*v rounded, back to a byte
  always_comb begin
    scaled = (BW'(s4_v) << 8) - BW'(s4_v) + BW'(FULL >> 1);
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      level <= scaled[2*F+7:2*F];
    end
  end

endmodule

@@ rtl/hslrgb_checker.sv @@
// Port-level checks for the HSL to RGB pixel converter, bound to the top level.
// Depends on hsl_to_rgb_pixel_macros.svh.
`include "hsl_to_rgb_pixel_macros.svh"

module hslrgb_checker #(
  parameter int FRAC_BITS = 16
) (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [FRAC_BITS:0] saturation,
  input logic               out_valid,
  input logic               out_ready,
  input logic [7:0]         red,
  input logic [7:0]         green,
  input logic [7:0]         blue
);

  `HSLRGB_CHECK_RESET(a_reset_empty, rst, !out_valid, "output valid after reset")
  `HSLRGB_CHECK_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `HSLRGB_CHECK_NEXT(a_latency, in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready, out_valid, "item not out after five cycles")
  `HSLRGB_CHECK_NEXT(a_gray, in_valid && in_ready && saturation == '0 ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready, out_valid && red == green && green == blue, "zero saturation not gray")

endmodule

bind hsl_to_rgb_pixel hslrgb_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (pix_in.valid),
  .in_ready   (pix_in.ready),
  .saturation (pix_in.saturation),
  .out_valid  (pix_out.valid),
  .out_ready  (pix_out.ready),
  .red        (pix_out.red),
  .green      (pix_out.green),
  .blue       (pix_out.blue)
);

@@ bench/hsl_to_rgb_pixel_checker.sv @@
// Scoreboard for the HSL to RGB pixel converter: predicts each color's bytes and checks pix_out.
// Depends on the hslrgb_in_if and hslrgb_out_if channel interfaces.
module hsl_to_rgb_pixel_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic   clk,
  input  logic   rst,
  hslrgb_in_if   pix_in,
  hslrgb_out_if  pix_out,
  output int     fail_count,
  output int     pending,
  output int     checked
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  localparam logic [63:0] ONE  = 64'd1 << FRAC_BITS;
  localparam logic [63:0] FULL = ONE << FRAC_BITS;

  rgb_t rgb_q[$];

  // floor(d * w / ONE) without overflow
  function automatic logic [63:0] ramp_scale(logic [63:0] d, logic [63:0] w);
    return (d >> FRAC_BITS) * w + (((d & (ONE - 1)) * w) >> FRAC_BITS);
  endfunction

  function automatic logic [63:0] hue_pos(logic [63:0] h, logic [63:0] offset);
    logic [63:0] u;
    u = 6 * h + offset;
    if (u >= 6 * ONE) u = u - 6 * ONE;
    return u;
  endfunction

  function automatic logic [7:0] channel_byte(logic [63:0] p2, logic [63:0] q2,
                                              logic [63:0] u);
    logic [63:0] d;
    logic [63:0] v;
    logic [63:0] scaled;
    d = (q2 >= p2) ? q2 - p2 : 64'd0;
    if (u < ONE) v = p2 + ramp_scale(d, u);
    else if (u < 3 * ONE) v = q2;
    else if (u < 4 * ONE) v = p2 + ramp_scale(d, 4 * ONE - u);
    else v = p2;
    if (v > FULL) v = FULL;
    scaled = (255 * v + (FULL >> 1)) >> (2 * FRAC_BITS);
    return scaled[7:0];
  endfunction

  function automatic rgb_t hsl_to_rgb_expected(logic [FRAC_BITS-1:0] hue,
                                               logic [FRAC_BITS:0] sat_raw,
                                               logic [FRAC_BITS:0] light_raw);
    logic [63:0] h;
    logic [63:0] s;
    logic [63:0] l;
    logic [63:0] q2;
    logic [63:0] p2;
    rgb_t c;
    h = 64'(hue);
    s = (64'(sat_raw) > ONE) ? ONE : 64'(sat_raw);
    l = (64'(light_raw) > ONE) ? ONE : 64'(light_raw);
    if (l < (ONE >> 1)) q2 = l * (ONE + s);
    else q2 = (l + s) * ONE - l * s;
    p2 = 2 * l * ONE;
    p2 = (p2 >= q2) ? p2 - q2 : 64'd0;
    c.red   = channel_byte(p2, q2, hue_pos(h, 2 * ONE));
    c.green = channel_byte(p2, q2, hue_pos(h, 0));
    c.blue  = channel_byte(p2, q2, hue_pos(h, 4 * ONE));
    return c;
  endfunction

  // append one predicted color at the tail of the queue
  task automatic queue_color(input rgb_t c);
    rgb_q = {rgb_q, c};
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  always @(posedge clk) begin
    rgb_t want;
    int   fails;
    if (!rst) begin
      fails = fail_count;
      if (pix_in.valid && pix_in.ready)
        queue_color(hsl_to_rgb_expected(pix_in.hue, pix_in.saturation,
                                        pix_in.lightness));
      if (pix_out.valid && pix_out.ready) begin
        if (rgb_q.size() == 0) begin
          $error("unexpected result item: red %0d green %0d blue %0d",
                 pix_out.red, pix_out.green, pix_out.blue);
          fails++;
        end else begin
          want = rgb_q.pop_front();
          if (pix_out.red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, pix_out.red);
            fails++;
          end
          if (pix_out.green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, pix_out.green);
            fails++;
          end
          if (pix_out.blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, pix_out.blue);
            fails++;
          end
          checked <= checked + 1;
        end
      end
      fail_count <= fails;
      pending    <= rgb_q.size();
    end
  end

endmodule

@@ bench/hsl_to_rgb_pixel_tb.sv @@
// Testbench top for hsl_to_rgb_pixel: clock, reset, bursty colors in, stalling output.
// Depends on hslrgb_pkg, hslrgb_if, the RTL and hsl_to_rgb_pixel_checker.
module hsl_to_rgb_pixel_tb;

  localparam int FRAC_BITS   = 16;
  localparam int RANDOM_ITEMS = 400;
  localparam int DRAIN_CYCLES = 30;
  localparam int CYCLE_LIMIT  = 200000;
  localparam logic [FRAC_BITS:0] UNIT = 17'd65536;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   checked;
  int   cycles;
  int   burst_left;
  int   directed_sent;
  int   random_sent;

  hslrgb_in_if #(.FRAC_BITS(FRAC_BITS)) pix_in();
  hslrgb_out_if                         pix_out();

  hsl_to_rgb_pixel #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in),
    .pix_out (pix_out)
  );

  hsl_to_rgb_pixel_checker #(.FRAC_BITS(FRAC_BITS)) checker_inst (
    .clk        (clk),
    .rst        (rst),
    .pix_in     (pix_in),
    .pix_out    (pix_out),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // receiver: cycles through four stall patterns: always ready, periodic stalls, random, square wave
  initial begin
    int pat_cnt;
    pat_cnt = 0;
    pix_out.ready = 1'b0;
    forever begin
      @(posedge clk);
      pat_cnt++;
      case ((pat_cnt / 128) % 4)
        0: begin
          pix_out.ready <= 1'b1;
        end
        1: begin
          pix_out.ready <= (pat_cnt % 5) != 4;
        end
        2: begin
          pix_out.ready <= $urandom_range(0, 1);
        end
        default: begin
          pix_out.ready <= pat_cnt[3];
        end
      endcase
    end
  end

  // sender: bursts of random length, random gaps between them
  task automatic put_color(input logic [FRAC_BITS-1:0] hue,
                           input logic [FRAC_BITS:0] sat,
                           input logic [FRAC_BITS:0] light);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        pix_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    pix_in.valid      <= 1'b1;
    pix_in.hue        <= hue;
    pix_in.saturation <= sat;
    pix_in.lightness  <= light;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
  endtask

  function automatic logic [FRAC_BITS:0] rand_unit_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return UNIT;
      2, 3: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  initial begin
    logic [FRAC_BITS-1:0] hue;
    logic [FRAC_BITS:0]   sat;
    logic [FRAC_BITS:0]   light;
    burst_left    = 0;
    directed_sent = 0;
    random_sent   = 0;
    rst = 1'b1;
    pix_in.valid      = 1'b0;
    pix_in.hue        = '0;
    pix_in.saturation = '0;
    pix_in.lightness  = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // field extremes, gray, above-one clamping, hue segment edges
    put_color(16'd0,     17'd0,      17'd0);
    put_color(16'd65535, 17'd131071, 17'd131071);
    put_color(16'd0,     UNIT,       17'd32768);
    put_color(16'd32768, UNIT,       17'd32768);
    put_color(16'd12345, 17'd0,      17'd40000);
    put_color(16'd54321, 17'd0,      UNIT);
    put_color(16'd10922, UNIT,       17'd32768);
    put_color(16'd10923, UNIT,       17'd32768);
    put_color(16'd21845, UNIT,       17'd32767);
    put_color(16'd21846, UNIT,       17'd32767);
    put_color(16'd43690, 17'd40000,  17'd32768);
    put_color(16'd43691, 17'd40000,  17'd32768);
    put_color(16'd54613, 17'd70000,  17'd20000);
    put_color(16'd54614, 17'd70000,  17'd20000);
    put_color(16'd65535, UNIT,       17'd1);
    put_color(16'd1,     17'd1,      17'd65535);
    put_color(16'd5000,  17'd131071, 17'd30000);
    put_color(16'd30000, 17'd30000,  17'd131071);
    put_color(16'd40000, UNIT,       UNIT);
    put_color(16'd60000, 17'd65535,  17'd0);
    directed_sent = 20;

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      hue   = 16'($urandom_range(0, 65535));
      sat   = rand_unit_value();
      light = ($urandom_range(0, 7) == 0) ? 17'($urandom_range(32760, 32776))
                                           : rand_unit_value();
      put_color(hue, sat, light);
      random_sent++;
    end

    pix_in.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d directed and %0d random colors in bursts against a stalling output",
             directed_sent, random_sent);
    $display("%0d results compared, %0d field errors", checked, fail_count);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ hsl_to_rgb_pixel.f @@
+incdir+rtl
rtl/hslrgb_pkg.sv
rtl/hslrgb_if.sv
rtl/hslrgb_front.sv
rtl/hslrgb_chan.sv
rtl/hsl_to_rgb_pixel.sv
rtl/hslrgb_checker.sv
bench/hsl_to_rgb_pixel_checker.sv
bench/hsl_to_rgb_pixel_tb.sv
